FILE: rtl/skbt_pkg.sv
// shared types and constants for the sorted keyed balance table
// no dependencies; used by skbt_alu and sorted_keyed_balance_table
package skbt_pkg;

  localparam int KEY_W  = 32;
  localparam int BAL_W  = 48;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 3;

  // action codes
  localparam logic [ACT_W-1:0] ACT_INSERT   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_QUERY    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DEPOSIT  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_WITHDRAW = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_DUPLICATE = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] STAT_INSUFF    = 3'd4;

  localparam logic signed [BAL_W-1:0] BAL_MAX = {1'b0, {(BAL_W-1){1'b1}}};
  localparam logic signed [BAL_W-1:0] BAL_MIN = {1'b1, {(BAL_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_BAL_RD,
    ST_BAL_UPD,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_INS_WR
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

FILE: rtl/skbt_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module skbt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: rtl/skbt_alu.sv
// shared 49-bit add/subtract unit with saturation to the 48-bit balance range
// depends on skbt_pkg
module skbt_alu (
  input  skbt_pkg::alu_op_t                  op,
  input  logic signed [skbt_pkg::BAL_W-1:0]  a,
  input  logic signed [skbt_pkg::BAL_W-1:0]  b,
  output logic signed [skbt_pkg::BAL_W-1:0]  res,
  output logic                               neg
);

  logic signed [skbt_pkg::BAL_W:0] a_ext;
  logic signed [skbt_pkg::BAL_W:0] b_ext;
  logic signed [skbt_pkg::BAL_W:0] sum;

  always_comb begin
    a_ext = {a[skbt_pkg::BAL_W-1], a};
    b_ext = {b[skbt_pkg::BAL_W-1], b};
    if (op == skbt_pkg::ALU_SUB) begin
      sum = a_ext - b_ext;
    end else begin
      sum = a_ext + b_ext;
    end
    neg = sum[skbt_pkg::BAL_W];
    // top two bits disagree: out of range, clamp
    if (sum[skbt_pkg::BAL_W] != sum[skbt_pkg::BAL_W-1]) begin
      res = sum[skbt_pkg::BAL_W] ? skbt_pkg::BAL_MIN : skbt_pkg::BAL_MAX;
    end else begin
      res = sum[skbt_pkg::BAL_W-1:0];
    end
  end

endmodule

FILE: rtl/sorted_keyed_balance_table.sv
// top level: sequencer, key and balance rams, shared add/subtract unit
// depends on skbt_pkg, skbt_ram, skbt_alu
//
// A table of up to CAPACITY accounts kept in ascending order of signed key, each with a
// signed 48-bit balance in cents. An action is taken when start is high and busy is low;
// busy then stays high until the single result appears on the out_ ports for exactly one
// cycle, marked by out_valid, which the receiver must take as it comes. Every access goes
// through the one read port of the key and balance rams, whose registered read gives each
// binary search step a read state and a compare state; over n held entries the search
// takes at most ceil(log2(n+1)) steps. A query, deposit or withdraw on a held key then
// reads its balance, a miss answers at the end of the search, and an insert moves each
// larger key up one place by a read and a write before writing the new entry. Inserting
// into a full table, or any other action on an empty one, answers at the next cycle without raising busy.
module sorted_keyed_balance_table #(
  parameter int CAPACITY = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [skbt_pkg::ACT_W-1:0]             in_action,
  input  logic signed [skbt_pkg::KEY_W-1:0]      in_account_key,
  input  logic signed [skbt_pkg::BAL_W-1:0]      in_amount,
  output logic                                   out_valid,
  output logic [skbt_pkg::STAT_W-1:0]            out_status,
  output logic signed [skbt_pkg::BAL_W-1:0]      out_balance,
  output logic [$clog2(CAPACITY+1)-1:0]          out_entry_count
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  skbt_pkg::state_t state_r, state_nxt;

  logic [skbt_pkg::ACT_W-1:0]        act_r;
  logic signed [skbt_pkg::KEY_W-1:0] key_r;
  logic signed [skbt_pkg::BAL_W-1:0] amt_r;
  logic [CW-1:0]                     lo_r;
  logic [CW-1:0]                     hi_r;
  logic [IW-1:0]                     mid_r;
  logic [IW-1:0]                     pos_r;
  logic [IW-1:0]                     i_r;
  logic [CW-1:0]                     count_r, count_nxt;

  logic                              out_valid_r;
  logic [skbt_pkg::STAT_W-1:0]       out_status_r;
  logic signed [skbt_pkg::BAL_W-1:0] out_balance_r;
  logic [CW-1:0]                     out_count_r;

  // ram ports
  logic [IW-1:0]                     raddr;
  logic [IW-1:0]                     waddr;
  logic                              key_we;
  logic                              bal_we;
  logic [skbt_pkg::KEY_W-1:0]        key_wdata;
  logic [skbt_pkg::BAL_W-1:0]        bal_wdata;
  logic [skbt_pkg::KEY_W-1:0]        key_rdata;
  logic [skbt_pkg::BAL_W-1:0]        bal_rdata;

  // search helpers
  logic [CW:0]                       mid_sum;
  logic [IW-1:0]                     mid;
  logic                              key_eq;
  logic                              key_lt;
  logic [CW-1:0]                     srch_lo_nxt;
  logic [CW-1:0]                     srch_hi_nxt;
  logic                              srch_miss;
  logic                              is_full;
  logic                              in_ins;
  logic                              act_ins;

  // alu
  skbt_pkg::alu_op_t                 alu_op;
  logic signed [skbt_pkg::BAL_W-1:0] alu_res;
  logic                              alu_neg;

  // finishing transaction
  logic                              fin;
  logic [skbt_pkg::STAT_W-1:0]       fin_status;
  logic signed [skbt_pkg::BAL_W-1:0] fin_bal;

  skbt_ram #(
    .WIDTH (skbt_pkg::KEY_W),
    .DEPTH (CAPACITY)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (waddr),
    .wdata (key_wdata),
    .raddr (raddr),
    .rdata (key_rdata)
  );

  skbt_ram #(
    .WIDTH (skbt_pkg::BAL_W),
    .DEPTH (CAPACITY)
  ) u_bal_ram (
    .clk   (clk),
    .we    (bal_we),
    .waddr (waddr),
    .wdata (bal_wdata),
    .raddr (raddr),
    .rdata (bal_rdata)
  );

  skbt_alu u_alu (
    .op  (alu_op),
    .a   ($signed(bal_rdata)),
    .b   (amt_r),
    .res (alu_res),
    .neg (alu_neg)
  );

  assign alu_op  = (act_r == skbt_pkg::ACT_WITHDRAW) ? skbt_pkg::ALU_SUB : skbt_pkg::ALU_ADD;
  assign is_full = (count_r == CW'(CAPACITY));
  assign in_ins  = (in_action == skbt_pkg::ACT_INSERT);
  assign act_ins = (act_r == skbt_pkg::ACT_INSERT);

  // midpoint of the open window [lo, hi)
  assign mid_sum = ({1'b0, lo_r} + {1'b0, hi_r}) - (CW+1)'(1);
  assign mid     = mid_sum[IW:1];

  assign key_eq      = ($signed(key_rdata) == key_r);
  assign key_lt      = ($signed(key_rdata) < key_r);
  assign srch_lo_nxt = key_lt ? (CW'(mid_r) + CW'(1)) : lo_r;
  assign srch_hi_nxt = key_lt ? hi_r : CW'(mid_r);
  assign srch_miss   = !key_eq && (srch_lo_nxt >= srch_hi_nxt);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      skbt_pkg::ST_IDLE: begin
        if (start) begin
          if (in_ins && is_full) begin
            state_nxt = skbt_pkg::ST_IDLE;
          end else if (count_r == '0) begin
            state_nxt = in_ins ? skbt_pkg::ST_INS_WR : skbt_pkg::ST_IDLE;
          end else begin
            state_nxt = skbt_pkg::ST_SRCH_RD;
          end
        end
      end
      skbt_pkg::ST_SRCH_RD: begin
        state_nxt = skbt_pkg::ST_SRCH_CMP;
      end
      skbt_pkg::ST_SRCH_CMP: begin
        if (key_eq) begin
          state_nxt = skbt_pkg::ST_BAL_RD;
        end else if (srch_miss) begin
          if (!act_ins) begin
            state_nxt = skbt_pkg::ST_IDLE;
          end else if (count_r == srch_lo_nxt) begin
            state_nxt = skbt_pkg::ST_INS_WR;
          end else begin
            state_nxt = skbt_pkg::ST_SHIFT_RD;
          end
        end else begin
          state_nxt = skbt_pkg::ST_SRCH_RD;
        end
      end
      skbt_pkg::ST_BAL_RD: begin
        state_nxt = skbt_pkg::ST_BAL_UPD;
      end
      skbt_pkg::ST_BAL_UPD: begin
        state_nxt = skbt_pkg::ST_IDLE;
      end
      skbt_pkg::ST_SHIFT_RD: begin
        state_nxt = skbt_pkg::ST_SHIFT_WR;
      end
      skbt_pkg::ST_SHIFT_WR: begin
        state_nxt = (CW'(i_r) == lo_r) ? skbt_pkg::ST_INS_WR : skbt_pkg::ST_SHIFT_RD;
      end
      skbt_pkg::ST_INS_WR: begin
        state_nxt = skbt_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = skbt_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer: ram control and result
  always_comb begin
    raddr      = mid;
    waddr      = i_r + IW'(1);
    key_we     = 1'b0;
    bal_we     = 1'b0;
    key_wdata  = key_rdata;
    bal_wdata  = bal_rdata;
    fin        = 1'b0;
    fin_status = skbt_pkg::STAT_OK;
    fin_bal    = '0;
    count_nxt  = count_r;
    unique case (state_r)
      skbt_pkg::ST_IDLE: begin
        if (start) begin
          if (in_ins && is_full) begin
            fin        = 1'b1;
            fin_status = skbt_pkg::STAT_FULL;
          end else if ((count_r == '0) && !in_ins) begin
            fin        = 1'b1;
            fin_status = skbt_pkg::STAT_NOT_FOUND;
          end
        end
      end
      skbt_pkg::ST_SRCH_RD: begin
        raddr = mid;
      end
      skbt_pkg::ST_SRCH_CMP: begin
        if (srch_miss && !act_ins) begin
          fin        = 1'b1;
          fin_status = skbt_pkg::STAT_NOT_FOUND;
        end
      end
      skbt_pkg::ST_BAL_RD: begin
        raddr = pos_r;
      end
      skbt_pkg::ST_BAL_UPD: begin
        fin       = 1'b1;
        fin_bal   = $signed(bal_rdata);
        waddr     = pos_r;
        bal_wdata = alu_res;
        case (act_r)
          skbt_pkg::ACT_INSERT: begin
            fin_status = skbt_pkg::STAT_DUPLICATE;
          end
          skbt_pkg::ACT_DEPOSIT: begin
            bal_we  = 1'b1;
            fin_bal = alu_res;
          end
          skbt_pkg::ACT_WITHDRAW: begin
            if (alu_neg) begin
              fin_status = skbt_pkg::STAT_INSUFF;
            end else begin
              bal_we  = 1'b1;
              fin_bal = alu_res;
            end
          end
          default: begin
            fin_status = skbt_pkg::STAT_OK;
          end
        endcase
      end
      skbt_pkg::ST_SHIFT_RD: begin
        raddr = i_r;
      end
      skbt_pkg::ST_SHIFT_WR: begin
        // move entry i up one place
        waddr  = i_r + IW'(1);
        key_we = 1'b1;
        bal_we = 1'b1;
      end
      skbt_pkg::ST_INS_WR: begin
        waddr     = lo_r[IW-1:0];
        key_we    = 1'b1;
        bal_we    = 1'b1;
        key_wdata = key_r;
        bal_wdata = amt_r;
        fin       = 1'b1;
        fin_bal   = amt_r;
        count_nxt = count_r + CW'(1);
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skbt_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= fin;
    end
  end

  // payload and search window
  always_ff @(posedge clk) begin
    if (fin) begin
      out_status_r  <= fin_status;
      out_balance_r <= fin_bal;
      out_count_r   <= count_nxt;
    end
    unique case (state_r)
      skbt_pkg::ST_IDLE: begin
        if (start) begin
          act_r <= in_action;
          key_r <= in_account_key;
          amt_r <= in_amount;
          lo_r  <= '0;
          hi_r  <= count_r;
        end
      end
      skbt_pkg::ST_SRCH_RD: begin
        mid_r <= mid;
      end
      skbt_pkg::ST_SRCH_CMP: begin
        lo_r  <= srch_lo_nxt;
        hi_r  <= srch_hi_nxt;
        pos_r <= mid_r;
        i_r   <= IW'(count_r - CW'(1));
      end
      skbt_pkg::ST_SHIFT_WR: begin
        i_r <= i_r - IW'(1);
      end
      default: begin
        mid_r <= mid_r;
      end
    endcase
  end

  assign busy            = (state_r != skbt_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_balance     = out_balance_r;
  assign out_entry_count = out_count_r;

endmodule
